// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold once the delay dly has passed after the antecedent.
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

`endif

// ===== src/sng_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the spectral noise gain pipeline.
// No dependencies.
package sng_pkg;

    localparam int DEN_W   = 49;   // widest denominator, s28 + n*knee
    localparam int REM_W   = 53;   // division remainder, below 16 * denominator
    localparam int Q_W     = 32;   // quotient with 28 fraction bits
    localparam int ROOT_W  = 16;
    localparam int SREM_W  = 18;
    localparam int DIV_STEPS  = Q_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int FRONT_STAGES = 4;
    localparam int SNG_LAT = FRONT_STAGES + DIV_STEPS + SQRT_STEPS + 1;

    localparam logic [15:0] UNITY_GAIN = 16'd16384;
    localparam logic [15:0] MAX_GAIN   = 16'hFFFF;
    localparam logic [15:0] ZERO_GAIN  = 16'd0;

    localparam logic [1:0] MODE_GATE   = 2'd0;
    localparam logic [1:0] MODE_WIENER = 2'd1;
    localparam logic [1:0] MODE_GSS    = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;   // unused, passes unity gain

    // Control that travels with every item down the pipeline.
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        byp;       // gain settled early, arithmetic ignored
        logic [15:0] byp_gain;
    } sng_ctl_t;

endpackage

// ===== src/sng_front.sv =====
`timescale 1ns / 1ps
// Front end: products, comparisons, mode selection and saturation check.
// Depends on sng_pkg; feeds the divider chain.
module sng_front
    import sng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [31:0]       signal_power,
    input  logic [31:0]       noise_power,
    input  logic [15:0]       oversub,
    input  logic [15:0]       floor_factor,
    input  logic [15:0]       knee_factor,
    input  logic              last_bin,
    input  logic [1:0]        gain_mode,
    output sng_ctl_t          ctl_out,
    output logic [REM_W-1:0]  rem_out,
    output logic [DEN_W-1:0]  den_out
);

    // Stage 1: products.
    logic        v1_reg, last1_reg;
    logic [43:0] s28_1_reg;
    logic [47:0] sn1_reg, nk1_reg, nb1_reg;
    logic [48:0] nab1_reg;
    logic        sz1_reg;

    // Stage 2: sums and comparisons.
    logic        v2_reg, last2_reg;
    logic [43:0] s28_2_reg;
    logic [47:0] sn2_reg, nb2_reg;
    logic [48:0] denw2_reg;
    logic        gate2_reg, gen2_reg, snz2_reg, sz2_reg;

    // Stage 3: selection.
    sng_ctl_t        ctl3_reg, ctl3_next;
    logic [48:0]     num3_reg, num3_next;
    logic [DEN_W-1:0] den3_reg, den3_next;

    // Stage 4: saturation check.
    sng_ctl_t         ctl4_reg, ctl4_next;
    logic [REM_W-1:0] rem4_reg;
    logic [DEN_W-1:0] den4_reg;

    logic [16:0] ab_sum;
    assign ab_sum = {1'b0, oversub} + {1'b0, floor_factor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            ctl3_reg <= ctl3_next;
            ctl4_reg <= ctl4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last1_reg <= last_bin;
        s28_1_reg <= {signal_power, 12'd0};
        sn1_reg   <= noise_power * oversub;
        nk1_reg   <= noise_power * knee_factor;
        nb1_reg   <= noise_power * floor_factor;
        nab1_reg  <= noise_power * ab_sum;
        sz1_reg   <= (signal_power == 32'd0);

        last2_reg <= last1_reg;
        s28_2_reg <= s28_1_reg;
        sn2_reg   <= sn1_reg;
        nb2_reg   <= nb1_reg;
        denw2_reg <= {5'd0, s28_1_reg} + {1'b0, nk1_reg};
        gate2_reg <= ({4'd0, s28_1_reg} >= sn1_reg);
        gen2_reg  <= (nab1_reg < {5'd0, s28_1_reg});
        snz2_reg  <= (sn1_reg == 48'd0);
        sz2_reg   <= sz1_reg;

        num3_reg <= num3_next;
        den3_reg <= den3_next;

        rem4_reg <= {4'd0, num3_reg};
        den4_reg <= den3_reg;
    end

    always_comb
    begin
        ctl3_next.valid    = v2_reg;
        ctl3_next.last     = last2_reg;
        ctl3_next.byp      = 1'b1;
        ctl3_next.byp_gain = UNITY_GAIN;
        num3_next = '0;
        den3_next = {{(DEN_W-1){1'b0}}, 1'b1};
        case (gain_mode)
            MODE_GATE:
            begin
                if (!snz2_reg && !gate2_reg)
                    ctl3_next.byp_gain = ZERO_GAIN;
            end
            MODE_WIENER:
            begin
                if (!snz2_reg)
                begin
                    if (denw2_reg > {1'b0, sn2_reg})
                    begin
                        ctl3_next.byp = 1'b0;
                        num3_next = denw2_reg - {1'b0, sn2_reg};
                        den3_next = denw2_reg;
                    end
                    else
                        ctl3_next.byp_gain = ZERO_GAIN;
                end
            end
            MODE_GSS:
            begin
                if (!sz2_reg)
                begin
                    ctl3_next.byp = 1'b0;
                    den3_next = {5'd0, s28_2_reg};
                    if (gen2_reg)
                        num3_next = {5'd0, s28_2_reg} - {1'b0, sn2_reg};
                    else
                        num3_next = {1'b0, nb2_reg};
                end
            end
            default:
            begin
                ctl3_next.byp = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        ctl4_next = ctl3_reg;
        if (!ctl3_reg.byp && ({4'd0, num3_reg} >= {den3_reg, 4'd0}))
        begin
            ctl4_next.byp      = 1'b1;
            ctl4_next.byp_gain = MAX_GAIN;
        end
    end

    assign ctl_out = ctl4_reg;
    assign rem_out = rem4_reg;
    assign den_out = den4_reg;

endmodule

// ===== src/sng_div_stage.sv =====
`timescale 1ns / 1ps
// One restoring division step: yields one quotient bit per stage.
// Depends on sng_pkg.
module sng_div_stage
    import sng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sng_ctl_t          ctl_in,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [Q_W-1:0]    q_in,
    output sng_ctl_t          ctl_out,
    output logic [REM_W-1:0]  rem_out,
    output logic [DEN_W-1:0]  den_out,
    output logic [Q_W-1:0]    q_out
);

    sng_ctl_t         ctl_reg;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg;
    logic [REM_W-1:0] d8;
    logic [REM_W-1:0] diff;
    logic             take;

    // The remainder stays below 16 times the divisor, so comparing against
    // 8 times the divisor and doubling yields one bit per step.
    assign d8   = {1'b0, den_in, 3'd0};
    assign take = (rem_in >= d8);
    assign diff = take ? (rem_in - d8) : rem_in;
    assign rem_next = {diff[REM_W-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_in;
        q_reg   <= {q_in[Q_W-2:0], take};
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;

endmodule

// ===== src/sng_sqrt_stage.sv =====
`timescale 1ns / 1ps
// One digit-by-digit square root step: yields one root bit per stage.
// Depends on sng_pkg.
module sng_sqrt_stage
    import sng_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sng_ctl_t           ctl_in,
    input  logic [Q_W-1:0]     v_in,
    input  logic [SREM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0]  root_in,
    output sng_ctl_t           ctl_out,
    output logic [Q_W-1:0]     v_out,
    output logic [SREM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0]  root_out
);

    sng_ctl_t            ctl_reg;
    logic [Q_W-1:0]      v_reg;
    logic [SREM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SREM_W+1:0]   cur;
    logic [SREM_W+1:0]   trial;
    logic                take;
    logic [SREM_W+1:0]   diff;

    assign cur   = {rem_in, v_in[Q_W-1:Q_W-2]};
    assign trial = {2'd0, root_in, 2'b01};
    assign take  = (cur >= trial);
    assign diff  = take ? (cur - trial) : cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= {v_in[Q_W-3:0], 2'b00};
        rem_reg  <= diff[SREM_W-1:0];
        root_reg <= {root_in[ROOT_W-2:0], take};
    end

    assign ctl_out  = ctl_reg;
    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ===== src/spectral_noise_gain.sv =====
`timescale 1ns / 1ps
// Top level of the per-bin spectral noise suppression gain pipeline.
// Depends on sng_pkg, sng_front, sng_div_stage and sng_sqrt_stage.
//
//  Channel   Handshake        Payload
//  -------   --------------   ---------------------------------------------------
//  input     start / busy     signal_power, noise_power, oversub, floor_factor,
//                             knee_factor, last_bin
//  result    done (strobe)    gain, last_out
//  config    cfg_we           cfg_wdata (gain_mode)
//
// One bin is taken in every clock cycle; busy is always low. Each bin's
// result passes through four front-end stages (products, comparisons,
// mode selection, saturation check), 32 restoring division stages,
// 16 square root stages and one output register before it sits on the
// result ports with done high.
// The division and square root chains each retire one result bit per stage.
// Reset clears the valid bits along the pipeline and sets gain_mode to Wiener.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module spectral_noise_gain
    import sng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] signal_power,
    input  logic [31:0] noise_power,
    input  logic [15:0] oversub,
    input  logic [15:0] floor_factor,
    input  logic [15:0] knee_factor,
    input  logic        last_bin,
    output logic        done,
    output logic [15:0] gain,
    output logic        last_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata
);

    logic [1:0] gain_mode_reg;

    // Mode register; the user must write it only while the pipeline is empty; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_mode_reg <= MODE_WIENER;
        else if (cfg_we)
            gain_mode_reg <= cfg_wdata;
    end

    assign busy = 1'b0;

    // Division chain wiring: index 0 is the front-end output.
    sng_ctl_t         dctl [DIV_STEPS+1];
    logic [REM_W-1:0] drem [DIV_STEPS+1];
    logic [DEN_W-1:0] dden [DIV_STEPS+1];
    logic [Q_W-1:0]   dq   [DIV_STEPS+1];

    sng_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .signal_power (signal_power),
        .noise_power  (noise_power),
        .oversub      (oversub),
        .floor_factor (floor_factor),
        .knee_factor  (knee_factor),
        .last_bin     (last_bin),
        .gain_mode    (gain_mode_reg),
        .ctl_out      (dctl[0]),
        .rem_out      (drem[0]),
        .den_out      (dden[0])
    );
    assign dq[0] = '0;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        sng_div_stage u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (dctl[i]),
            .rem_in  (drem[i]),
            .den_in  (dden[i]),
            .q_in    (dq[i]),
            .ctl_out (dctl[i+1]),
            .rem_out (drem[i+1]),
            .den_out (dden[i+1]),
            .q_out   (dq[i+1])
        );
    end

    // Square root chain: the quotient carries 28 fraction bits, so its
    // integer root is the gain with 14 fraction bits.
    sng_ctl_t          sctl  [SQRT_STEPS+1];
    logic [Q_W-1:0]    sv    [SQRT_STEPS+1];
    logic [SREM_W-1:0] srem  [SQRT_STEPS+1];
    logic [ROOT_W-1:0] sroot [SQRT_STEPS+1];

    assign sctl[0]  = dctl[DIV_STEPS];
    assign sv[0]    = dq[DIV_STEPS];
    assign srem[0]  = '0;
    assign sroot[0] = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        sng_sqrt_stage u_sqrt (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (sctl[j]),
            .v_in     (sv[j]),
            .rem_in   (srem[j]),
            .root_in  (sroot[j]),
            .ctl_out  (sctl[j+1]),
            .v_out    (sv[j+1]),
            .rem_out  (srem[j+1]),
            .root_out (sroot[j+1])
        );
    end

    // Output register: a bypassed bin takes its settled gain.
    logic        done_reg;
    logic [15:0] gain_reg;
    logic        last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sctl[SQRT_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        gain_reg <= sctl[SQRT_STEPS].byp ? sctl[SQRT_STEPS].byp_gain : sroot[SQRT_STEPS];
        last_reg <= sctl[SQRT_STEPS].last;
    end

    assign done     = done_reg;
    assign gain     = gain_reg;
    assign last_out = last_reg;

endmodule

// ===== src/sng_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for spectral_noise_gain, bound to the top level.
// Depends on sng_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sng_port_checker
    import sng_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_bin,
    input logic done,
    input logic last_out
);

    // The block never refuses a transfer.
    `ASSERT_NEVER(a_never_busy, clk, rst_n, busy)
    // Every transfer yields a result once it has passed the whole pipeline.
    `ASSERT_DELAY(a_result_follows, clk, rst_n, start, SNG_LAT, done)
    // A last-bin mark comes out with its own bin.
    `ASSERT_DELAY(a_last_kept, clk, rst_n, start && last_bin, SNG_LAT, last_out)
    `ASSERT_DELAY(a_nolast_kept, clk, rst_n, start && !last_bin, SNG_LAT, !last_out)
    // No result without a transfer at the matching earlier cycle.
    `ASSERT_IMPL(a_no_invented, clk, rst_n, done, $past(start, SNG_LAT))

endmodule

bind spectral_noise_gain sng_port_checker u_sng_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .last_bin (last_bin),
    .done     (done),
    .last_out (last_out)
);
